// ===== sv/tec_pkg.sv =====
// tec_pkg: shared types, constants and divider constants for the tilt event counter.
// Depends on nothing; used by every module of the block.
package tec_pkg;

  // window length and derived widths
  localparam int WINDOW = 10;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = 16 + $clog2(WINDOW);
  // reciprocal for divide by WINDOW: exact while |sum| * (M*WINDOW - 2^K) < 2^K
  localparam int DIV_K  = SUM_W + 6;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;
  localparam int M_W    = DIV_K + 1 - $clog2(WINDOW);
  localparam int PROD_W = SUM_W + M_W;

  localparam int PADDR_W = 4;
  localparam logic [31:0] PDATA_ZERO = 32'd0;

  localparam logic [14:0] TILT_THR_RST   = 15'd3000;
  localparam logic [7:0]  SAMPLES_RST    = 8'd10;
  localparam logic [7:0]  EVT_LIMIT_RST  = 8'd3;
  localparam logic [7:0]  COUNT_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    REG_TILT_THR  = 2'd0,
    REG_SAMPLES   = 2'd1,
    REG_EVT_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_SAVING  = 2'd2,
    MODE_WAITRET = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EVT_NONE    = 3'd0,
    EVT_STARTED = 3'd1,
    EVT_STOPPED = 3'd2,
    EVT_TILT    = 3'd3,
    EVT_SAVED   = 3'd4,
    EVT_REARMED = 3'd5
  } evt_e;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] accel_z;
    logic [11:0]       adc_code;
  } tec_in_t;

  typedef struct packed {
    logic              record_valid;
    logic signed [15:0] record_accel_z;
    logic [11:0]       record_adc;
    logic [1:0]        mode;
    logic [7:0]        event_total;
    logic [2:0]        event_code;
    logic signed [15:0] window_mean;
  } tec_out_t;

  typedef struct packed {
    logic [14:0] tilt_threshold;
    logic [7:0]  samples_per_event;
    logic [7:0]  event_limit;
  } tec_cfg_t;

  typedef struct packed {
    logic push;
    logic clear;
  } tec_win_ctrl_t;

endpackage

// ===== sv/tilt_event_counter.sv =====
// tilt_event_counter: top level; input register, window and control logic, result register.
// Depends on tec_pkg, tec_cfg, tec_window, tec_ctrl.
// An accepted input beat goes through the input register, then the result register.
// Throughput: one item per cycle unless out_stall_i holds a full result register; the window
// sum, the reciprocal multiply and the mode update all sit between the input and result registers.
// Reset (rst_ni low, asynchronous): mode idle, counters and window fill cleared,
// registers at their defaults; both pipeline stages empty. No clearing pass.
module tilt_event_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tec_pkg::tec_in_t            in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tec_pkg::tec_out_t           out_data_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tec_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                   in_valid_q, out_valid_q;
  tec_pkg::tec_in_t       in_q;
  tec_pkg::tec_out_t      out_q, res;
  tec_pkg::tec_cfg_t      cfg;
  tec_pkg::tec_win_ctrl_t win_ctrl;
  logic signed [15:0]     mean;
  logic                   adv, step, in_take;

  // The result register frees whenever it is empty or being taken; the input
  // register then hands its beat through and can take a new one the same cycle.
  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  tec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // window only moves on ticks outside idle; start clears fill and sum
  tec_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .z_i    (in_q.accel_z),
    .mean_o (mean)
  );

  tec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .mean_i (mean),
    .win_o  (win_ctrl),
    .res_o  (res)
  );

endmodule

// ===== sv/tec_cfg.sv =====
// tec_cfg: APB-style configuration registers of the tilt event counter.
// Depends on tec_pkg.
module tec_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tec_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tec_pkg::tec_cfg_t             cfg_o
);

  tec_pkg::tec_cfg_t cfg_q;
  logic              wr_en;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_threshold    <= tec_pkg::TILT_THR_RST;
      cfg_q.samples_per_event <= tec_pkg::SAMPLES_RST;
      cfg_q.event_limit       <= tec_pkg::EVT_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        tec_pkg::REG_TILT_THR:  cfg_q.tilt_threshold    <= pwdata[14:0];
        tec_pkg::REG_SAMPLES:   cfg_q.samples_per_event <= pwdata[7:0];
        tec_pkg::REG_EVT_LIMIT: cfg_q.event_limit       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tec_pkg::REG_TILT_THR:  prdata = {17'd0, cfg_q.tilt_threshold};
      tec_pkg::REG_SAMPLES:   prdata = {24'd0, cfg_q.samples_per_event};
      tec_pkg::REG_EVT_LIMIT: prdata = {24'd0, cfg_q.event_limit};
      default:                prdata = tec_pkg::PDATA_ZERO;
    endcase
  end

endmodule

// ===== sv/tec_window.sv =====
// tec_window: shift window of Z samples, running sum and truncating mean.
// Depends on tec_pkg.
module tec_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tec_pkg::tec_win_ctrl_t ctrl_i,
  input  logic signed [15:0]    z_i,
  output logic signed [15:0]    mean_o
);

  logic signed [15:0]               win_q [tec_pkg::WINDOW];
  logic [tec_pkg::FILL_W-1:0]       fill_q, fill_d;
  logic signed [tec_pkg::SUM_W-1:0] sum_q, sum_d, drop;
  logic [tec_pkg::SUM_W-1:0]        mag;
  logic [tec_pkg::PROD_W-1:0]       prod;
  logic [15:0]                      quo;
  logic                             full_now, full_next, neg;

  // samples beyond fill are never read, so no reset on the line
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      win_q[0] <= z_i;
      for (int i = 1; i < tec_pkg::WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_comb begin
    full_now  = (fill_q == tec_pkg::FILL_W'(tec_pkg::WINDOW));
    fill_d    = full_now ? fill_q : fill_q + tec_pkg::FILL_W'(1);
    full_next = (fill_d == tec_pkg::FILL_W'(tec_pkg::WINDOW));
    drop      = full_now ? tec_pkg::SUM_W'(win_q[tec_pkg::WINDOW-1])
                         : tec_pkg::SUM_W'(0);
    sum_d     = sum_q + tec_pkg::SUM_W'(z_i) - drop;
    // signed divide toward zero: divide magnitude, restore sign
    neg       = sum_d[tec_pkg::SUM_W-1];
    mag       = neg ? tec_pkg::SUM_W'(-sum_d) : tec_pkg::SUM_W'(sum_d);
    prod      = tec_pkg::PROD_W'(mag) * tec_pkg::PROD_W'(tec_pkg::DIV_M);
    quo       = 16'(prod >> tec_pkg::DIV_K);
    if (!full_next) begin
      mean_o = 16'sd0;
    end else if (neg) begin
      mean_o = -$signed(quo);
    end else begin
      mean_o = $signed(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.clear) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.push) begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ===== sv/tec_ctrl.sv =====
// tec_ctrl: mode state machine, event and burst counters, result assembly.
// Depends on tec_pkg.
module tec_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  tec_pkg::tec_in_t       item_i,
  input  tec_pkg::tec_cfg_t      cfg_i,
  input  logic signed [15:0]     mean_i,
  output tec_pkg::tec_win_ctrl_t win_o,
  output tec_pkg::tec_out_t      res_o
);

  tec_pkg::mode_e     mode_q, mode_d;
  tec_pkg::evt_e      code;
  logic [7:0]         event_q, event_d, saved_q, saved_d, saved_inc;
  logic               tick;
  logic signed [16:0] mean17, thr17;

  assign tick   = !item_i.operation && (mode_q != tec_pkg::MODE_IDLE);
  assign mean17 = 17'(mean_i);
  assign thr17  = $signed({2'b00, cfg_i.tilt_threshold});
  assign saved_inc = (saved_q < tec_pkg::COUNT_MAX) ? saved_q + 8'd1 : saved_q;

  assign win_o.push  = step_i && tick;
  assign win_o.clear = step_i && item_i.operation && (mode_q == tec_pkg::MODE_IDLE);

  // next state and counters
  always_comb begin
    mode_d  = mode_q;
    event_d = event_q;
    saved_d = saved_q;
    code    = tec_pkg::EVT_NONE;
    if (item_i.operation) begin
      if (mode_q == tec_pkg::MODE_IDLE) begin
        mode_d  = tec_pkg::MODE_ARMED;
        event_d = 8'd0;
        saved_d = 8'd0;
        code    = tec_pkg::EVT_STARTED;
      end else begin
        mode_d = tec_pkg::MODE_IDLE;
        code   = tec_pkg::EVT_STOPPED;
      end
    end else begin
      case (mode_q)
        tec_pkg::MODE_ARMED: begin
          if (mean17 < -thr17) begin
            mode_d  = tec_pkg::MODE_SAVING;
            event_d = (event_q < tec_pkg::COUNT_MAX) ? event_q + 8'd1 : event_q;
            code    = tec_pkg::EVT_TILT;
          end
        end
        tec_pkg::MODE_SAVING: begin
          saved_d = saved_inc;
          if (saved_inc >= cfg_i.samples_per_event) begin
            mode_d  = tec_pkg::MODE_WAITRET;
            saved_d = 8'd0;
            code    = tec_pkg::EVT_SAVED;
          end
        end
        tec_pkg::MODE_WAITRET: begin
          if (event_q >= cfg_i.event_limit) begin
            mode_d = tec_pkg::MODE_IDLE;
            code   = tec_pkg::EVT_REARMED;
          end else if (mean17 > thr17) begin
            mode_d = tec_pkg::MODE_ARMED;
            code   = tec_pkg::EVT_REARMED;
          end
        end
        default: ;
      endcase
    end
  end

  // result beat
  always_comb begin
    res_o.record_valid   = tick && (mode_q == tec_pkg::MODE_SAVING);
    res_o.record_accel_z = res_o.record_valid ? item_i.accel_z : 16'sd0;
    res_o.record_adc     = res_o.record_valid ? item_i.adc_code : 12'd0;
    res_o.mode           = mode_d;
    res_o.event_total    = event_d;
    res_o.event_code     = code;
    res_o.window_mean    = tick ? mean_i : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tec_pkg::MODE_IDLE;
      event_q <= 8'd0;
      saved_q <= 8'd0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      event_q <= event_d;
      saved_q <= saved_d;
    end
  end

  // saving is only reached through a counted tilt
  a_saving_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tec_pkg::MODE_SAVING) |-> (event_q != 8'd0))
    else $error("saving with zero event count");

  // burst counter is cleared before it can saturate
  a_saved_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saved_q != tec_pkg::COUNT_MAX)
    else $error("burst counter reached saturation");

  // a tick in idle leaves the machine idle
  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !item_i.operation && mode_q == tec_pkg::MODE_IDLE)
      |=> (mode_q == tec_pkg::MODE_IDLE))
    else $error("idle tick changed mode");

endmodule

// ===== bench/tec_event_checker.sv =====
`timescale 1ns / 1ps
// tec_event_checker: follows the input, result and register channels of the tilt event
// counter, predicts every result beat and compares it field by field.
// Depends on tec_pkg for the beat structs, modes, event codes and register indexes.
module tec_event_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  tec_pkg::tec_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  tec_pkg::tec_out_t           out_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [tec_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        pready_i,
  output tec_pkg::mode_e              mode_o,
  output int                          pending_o,
  output int                          items_o,
  output int                          results_o,
  output int                          records_o,
  output int                          tilts_o,
  output int                          n_fail_o
);
  import tec_pkg::*;

  localparam int SHOW_MAX = 40;

  // register copies
  logic [14:0] tilt_thr;
  logic [7:0]  burst_len;
  logic [7:0]  evt_limit;

  // mirrored block state
  mode_e              mode_q;
  logic signed [15:0] zwin [WINDOW];
  int                 fill_q;
  logic [7:0]         events_q;
  logic [7:0]         saved_q;

  tec_out_t expected_results[$];
  int n_items, n_results, n_records, n_tilts, n_fail;

  // works out the result beat of one accepted input beat and advances the mirror
  function automatic tec_out_t next_tilt_result(input tec_in_t beat);
    tec_out_t r;
    int       sum;
    int       mean;
    int       thr;
    int       i;
    r    = '0;
    mean = 0;
    thr  = int'(tilt_thr);
    r.event_code = EVT_NONE;
    if (beat.operation) begin
      if (mode_q == MODE_IDLE) begin
        mode_q   = MODE_ARMED;
        fill_q   = 0;
        events_q = '0;
        saved_q  = '0;
        r.event_code = EVT_STARTED;
      end else begin
        mode_q = MODE_IDLE;
        r.event_code = EVT_STOPPED;
      end
    end else if (mode_q != MODE_IDLE) begin
      if (fill_q < WINDOW) fill_q++;
      for (i = WINDOW - 1; i > 0; i--) zwin[i] = zwin[i-1];
      zwin[0] = beat.accel_z;
      if (fill_q == WINDOW) begin
        sum = 0;
        for (i = 0; i < WINDOW; i++) sum += zwin[i];
        mean = sum / WINDOW;   // truncates toward zero
      end
      case (mode_q)
        MODE_WAITRET: begin
          if (events_q >= evt_limit) begin
            mode_q = MODE_IDLE;
            r.event_code = EVT_REARMED;
          end else if (mean > thr) begin
            mode_q = MODE_ARMED;
            r.event_code = EVT_REARMED;
          end
        end
        MODE_ARMED: begin
          if (mean < -thr) begin
            mode_q = MODE_SAVING;
            if (events_q != COUNT_MAX) events_q++;
            r.event_code = EVT_TILT;
          end
        end
        default: begin
          r.record_valid   = 1'b1;
          r.record_accel_z = beat.accel_z;
          r.record_adc     = beat.adc_code;
          if (saved_q != COUNT_MAX) saved_q++;
          if (saved_q >= burst_len) begin
            mode_q  = MODE_WAITRET;
            saved_q = '0;
            r.event_code = EVT_SAVED;
          end
        end
      endcase
    end
    r.mode        = mode_q;
    r.event_total = events_q;
    r.window_mean = mean[15:0];
    return r;
  endfunction

  function automatic void report_fail(input string what);
    n_fail++;
    if (n_fail <= SHOW_MAX) $display("%0t: %s", $time, what);
    else if (n_fail == SHOW_MAX + 1) $display("%0t: further mismatches not shown", $time);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) report_fail($sformatf("%s expected %h, got %h", name, want, got));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tec_out_t want;
    tec_out_t got;
    if (!rst_ni) begin
      tilt_thr  = TILT_THR_RST;
      burst_len = SAMPLES_RST;
      evt_limit = EVT_LIMIT_RST;
      mode_q    = MODE_IDLE;
      fill_q    = 0;
      events_q  = '0;
      saved_q   = '0;
      expected_results.delete();
      mode_o    <= MODE_IDLE;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:2]))
          REG_TILT_THR:  tilt_thr  = pwdata_i[14:0];
          REG_SAMPLES:   burst_len = pwdata_i[7:0];
          REG_EVT_LIMIT: evt_limit = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        // every accepted beat counts, idle ticks included
        n_items++;
        expected_results.push_back(next_tilt_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        n_results++;
        if (expected_results.size() == 0) begin
          report_fail($sformatf("result beat with nothing expected: %h", got));
        end else begin
          want = expected_results.pop_front();
          if (want.record_valid) n_records++;
          if (want.event_code == EVT_TILT) n_tilts++;
          check_field("record_valid", 16'(want.record_valid), 16'(got.record_valid));
          check_field("record_accel_z", want.record_accel_z, got.record_accel_z);
          check_field("record_adc", 16'(want.record_adc), 16'(got.record_adc));
          check_field("mode", 16'(want.mode), 16'(got.mode));
          check_field("event_total", 16'(want.event_total), 16'(got.event_total));
          check_field("event_code", 16'(want.event_code), 16'(got.event_code));
          check_field("window_mean", want.window_mean, got.window_mean);
        end
      end
      mode_o    <= mode_q;
      pending_o <= expected_results.size();
    end
  end

  assign items_o   = n_items;
  assign results_o = n_results;
  assign records_o = n_records;
  assign tilts_o   = n_tilts;
  assign n_fail_o  = n_fail;

  initial begin
    n_items   = 0;
    n_results = 0;
    n_records = 0;
    n_tilts   = 0;
    n_fail    = 0;
  end

endmodule

// ===== bench/tilt_event_counter_tb.sv =====
`timescale 1ns / 1ps
// tilt_event_counter_tb: stimulus and verdict for the tilt event counter.
// Depends on tec_pkg, the tilt_event_counter RTL and tec_event_checker.
module tilt_event_counter_tb;
  import tec_pkg::*;

  // index three has no register behind it; writes there must be dropped
  localparam logic [1:0] SPARE_REG = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tec_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tec_out_t out_data;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;

  // calm: set for the closing stretch, no gaps on either side from then on
  logic  calm;
  int    thr_cur;
  int    n_settings;
  mode_e mode_now;
  int    pending, items, results, records, tilts, n_fail;

  tilt_event_counter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tec_event_checker i_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .mode_o      (mode_now),
    .pending_o   (pending),
    .items_o     (items),
    .results_o   (results),
    .records_o   (records),
    .tilts_o     (tilts),
    .n_fail_o    (n_fail)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: stall bursts between quiet stretches, until calm is set
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one beat on the input channel; returns at the edge that accepts it, valid left high
  task automatic send_beat(input tec_in_t beat);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic tick(input int z, input int adc);
    tec_in_t beat;
    beat.operation = 1'b0;
    beat.accel_z   = z[15:0];
    beat.adc_code  = adc[11:0];
    send_beat(beat);
  endtask

  // button press; the sample fields are don't-care, so fill them with junk
  task automatic press();
    tec_in_t beat;
    beat.operation = 1'b1;
    beat.accel_z   = 16'($urandom);
    beat.adc_code  = 12'($urandom);
    send_beat(beat);
  endtask

  // drop valid, then let the checker's mode catch up with every accepted beat
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every outstanding result to arrive (pipeline is two deep)
  task automatic drain();
    settle();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup phase, access phase until pready, then the port goes idle before anything else on it
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retune(input int thr, input int spe, input int lim);
    drain();
    apb_write(REG_TILT_THR, 32'(thr));
    apb_write(REG_SAMPLES, 32'(spe));
    apb_write(REG_EVT_LIMIT, 32'(lim));
    thr_cur = thr;
    n_settings++;
  endtask

  // a run of ticks around one Z level; outside the calm stretch a stray press
  // now and then breaks the sequence
  task automatic run_level(input int level, input int len, input int amp);
    int n;
    for (n = 0; n < len; n++) begin
      if (!calm && $urandom_range(0, 39) == 0)
        press();
      else
        tick(clamp16(level + int'($urandom_range(0, 2 * amp)) - amp),
             int'($urandom_range(0, 4095)));
    end
  endtask

  // mostly well-formed tilt/return swings, some neutral and some pure noise
  task automatic random_phase(input int goal);
    int pick;
    int len;
    while (items < goal) begin
      settle();
      if (mode_now == MODE_IDLE) press();
      pick = int'($urandom_range(0, 9));
      len  = int'($urandom_range(3, 16));
      if (pick < 4)
        run_level(-thr_cur - 1 - int'($urandom_range(0, 2000)), len, 64);
      else if (pick < 8)
        run_level(thr_cur + 1 + int'($urandom_range(0, 2000)), len, 64);
      else if (pick == 8)
        run_level(0, len, 32768);
      else
        run_level(int'($urandom_range(0, 2 * thr_cur)) - thr_cur, len, 0);
    end
  endtask

  initial begin
    int k;
    calm       = 1'b0;
    thr_cur    = int'(TILT_THR_RST);
    n_settings = 1;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, register defaults: a tick while idle is swallowed, then one
    // full cycle start -> tilt -> burst of ten -> return -> stop
    tick(-32768, 4095);
    press();
    for (k = 0; k < 10; k++) tick(-32768, k * 455);         // tilt on the tenth
    for (k = 0; k < 10; k++) tick(32767, 4095 - k * 455);   // forwarded burst
    tick(32767, 0);                                          // back to armed
    press();

    // zero burst length still forwards one sample; zero limit ends at once
    retune(0, 0, 0);
    apb_write(SPARE_REG, 32'hFFFF_FFFF);
    random_phase(items + 95);

    // widest settings: only an all-minimum window can tilt, never returns
    retune(32767, 255, 255);
    random_phase(items + 95);

    // limit now likely below the count carried over
    retune(0, 1, 1);
    random_phase(items + 95);

    retune(int'($urandom_range(200, 6000)), int'($urandom_range(1, 12)),
           int'($urandom_range(1, 6)));
    random_phase(items + 95);

    retune(3000, 3, 2);
    random_phase(items + 95);

    retune(int'($urandom_range(0, 12000)), int'($urandom_range(1, 40)),
           int'($urandom_range(1, 255)));
    random_phase(items + 90);

    // closing stretch: steady swings, no gaps and no stalls
    retune(1000, 4, 200);
    settle();
    if (mode_now == MODE_IDLE) press();
    calm = 1'b1;
    while (items < 650) begin
      run_level(-thr_cur - 1 - int'($urandom_range(0, 2000)), 12, 64);
      run_level(thr_cur + 1 + int'($urandom_range(0, 2000)), 12, 64);
    end

    settle();
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d input beats and %0d result beats over %0d register settings,",
             items, results, n_settings);
    $display("including %0d forwarded samples and %0d tilt detections.", records, tilts);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
